// ----- rtl/core/icpt_pkg.sv -----
// ----------------------------------------------------------------------------
// icpt_pkg
// shared types and constants of the intercept time solver
// ----------------------------------------------------------------------------
package icpt_pkg;

	localparam int FRAC_BITS = 16;
	localparam int RAD_W     = 128;
	localparam int ROOT_W    = 64;
	localparam int MAG_W     = 64;
	localparam int QUO_W     = 32;
	localparam int NUM_W     = 65 + FRAC_BITS;
	localparam int DIV_W     = (NUM_W > 96) ? NUM_W : 96;

	typedef struct packed {
		logic signed [31:0] disp_x;
		logic signed [31:0] disp_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic [30:0]        pursuer_speed;
	} in_t;

	typedef struct packed {
		logic [31:0] meet_time;
		logic        no_solution;
		logic        saturated;
	} out_t;

	// values carried alongside the square root
	typedef struct packed {
		logic [MAG_W-1:0] c;
		logic [MAG_W-1:0] hm;
		logic             hneg;
		logic [MAG_W-1:0] am;
		logic             aneg;
		logic             ok;
	} side_t;

endpackage

// ----- rtl/core/icpt_sqrt.sv -----
// ----------------------------------------------------------------------------
// icpt_sqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module icpt_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_vld,
	input  logic [icpt_pkg::RAD_W-1:0]    in_rad,
	input  icpt_pkg::side_t               in_side,
	output logic                          out_vld,
	output logic [icpt_pkg::ROOT_W-1:0]   out_root,
	output icpt_pkg::side_t               out_side
);
	import icpt_pkg::*;

	logic              vld_s  [0:ROOT_W];
	logic [RAD_W-1:0]  rem_s  [0:ROOT_W];
	logic [ROOT_W-1:0] root_s [0:ROOT_W];
	side_t             side_s [0:ROOT_W];

	assign vld_s[0]  = in_vld;
	assign rem_s[0]  = in_rad;
	assign root_s[0] = '0;
	assign side_s[0] = in_side;

	for (genvar k = 1; k <= ROOT_W; k++) begin : g_stage
		localparam int B = ROOT_W - k;
		logic [RAD_W-1:0] trial;
		logic             take;

		always_comb begin
			trial = (RAD_W'(root_s[k-1]) << (B + 1)) | (RAD_W'(1) << (2 * B));
			take  = rem_s[k-1] >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= take ? (rem_s[k-1] - trial) : rem_s[k-1];
			root_s[k] <= take ? (root_s[k-1] | (ROOT_W'(1) << B)) : root_s[k-1];
			side_s[k] <= side_s[k-1];
		end
	end

	assign out_vld  = vld_s[ROOT_W];
	assign out_root = root_s[ROOT_W];
	assign out_side = side_s[ROOT_W];

endmodule

// ----- rtl/core/icpt_div.sv -----
// ----------------------------------------------------------------------------
// icpt_div
// pipelined restoring divider with range check, one quotient bit per stage
// ----------------------------------------------------------------------------
module icpt_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_vld,
	input  logic                         in_found,
	input  logic [icpt_pkg::NUM_W-1:0]   in_num,
	input  logic [icpt_pkg::MAG_W-1:0]   in_den,
	output logic                         out_vld,
	output logic                         out_found,
	output logic                         out_sat,
	output logic [icpt_pkg::QUO_W-1:0]   out_quo
);
	import icpt_pkg::*;

	logic             vld_s   [0:QUO_W];
	logic             found_s [0:QUO_W];
	logic             sat_s   [0:QUO_W];
	logic [DIV_W-1:0] rem_s   [0:QUO_W];
	logic [MAG_W-1:0] den_s   [0:QUO_W];
	logic [QUO_W-1:0] quo_s   [0:QUO_W];

	logic [DIV_W-1:0] num_ext;
	logic [DIV_W-1:0] lim;

	always_comb begin
		num_ext = DIV_W'(in_num);
		lim     = DIV_W'(in_den) << QUO_W;
	end

	// range check stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		found_s[0] <= in_found;
		sat_s[0]   <= in_found && (num_ext >= lim);
		rem_s[0]   <= num_ext;
		den_s[0]   <= in_den;
		quo_s[0]   <= '0;
	end

	for (genvar j = 1; j <= QUO_W; j++) begin : g_stage
		localparam int I = QUO_W - j;
		logic [DIV_W-1:0] trial;
		logic             take;

		always_comb begin
			trial = DIV_W'(den_s[j-1]) << I;
			take  = rem_s[j-1] >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else begin
				vld_s[j] <= vld_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			found_s[j] <= found_s[j-1];
			sat_s[j]   <= sat_s[j-1];
			den_s[j]   <= den_s[j-1];
			rem_s[j]   <= take ? (rem_s[j-1] - trial) : rem_s[j-1];
			quo_s[j]   <= {quo_s[j-1][QUO_W-2:0], take};
		end
	end

	assign out_vld   = vld_s[QUO_W];
	assign out_found = found_s[QUO_W];
	assign out_sat   = sat_s[QUO_W];
	assign out_quo   = quo_s[QUO_W];

endmodule

// ----- rtl/core/intercept_time_solver.sv -----
// ----------------------------------------------------------------------------
// intercept_time_solver
// smallest positive root of the constant velocity intercept quadratic
// ----------------------------------------------------------------------------
// a request is taken on any rising edge with start high and busy low; busy is
// never raised, so one request may enter on every clock cycle
// each request gives exactly one result on res, marked by done for one cycle
// the pipeline holds 5 product and sum stages, 64 square root
// stages (one root bit each), one root select stage, one range check stage
// and 32 divider stages (one quotient bit each)
// throughput is one request per cycle, results leave in request order
// the receiver cannot hold results off, so nothing inside ever stalls
// reset clears every valid bit; requests in flight are dropped and no done
// strobe is raised until a new request has passed the whole pipeline
// meet_time is zero with no_solution set when no positive root exists, and all
// ones with saturated set when the time is beyond the output range
// ----------------------------------------------------------------------------
module intercept_time_solver (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  icpt_pkg::in_t  req,
	output logic           done,
	output icpt_pkg::out_t res
);
	import icpt_pkg::*;

	logic acc;
	logic dxn, dyn, vxn, vyn;
	logic [31:0] dxm, dym, vxm, vym;

	assign busy = 1'b0;
	assign acc  = start && !busy;

	always_comb begin
		dxn = req.disp_x[31];
		dyn = req.disp_y[31];
		vxn = req.vel_x[31];
		vyn = req.vel_y[31];
		dxm = dxn ? 32'(-req.disp_x) : 32'(req.disp_x);
		dym = dyn ? 32'(-req.disp_y) : 32'(req.disp_y);
		vxm = vxn ? 32'(-req.vel_x) : 32'(req.vel_x);
		vym = vyn ? 32'(-req.vel_y) : 32'(req.vel_y);
	end

	// stage 1: squares and cross products
	logic        vld_s1;
	logic [63:0] dxx_s1, dyy_s1, vxx_s1, vyy_s1, ss_s1, hx_s1, hy_s1;
	logic        hxn_s1, hyn_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		dxx_s1 <= dxm * dxm;
		dyy_s1 <= dym * dym;
		vxx_s1 <= vxm * vxm;
		vyy_s1 <= vym * vym;
		ss_s1  <= 64'(req.pursuer_speed) * 64'(req.pursuer_speed);
		hx_s1  <= dxm * vxm;
		hy_s1  <= dym * vym;
		hxn_s1 <= dxn ^ vxn;
		hyn_s1 <= dyn ^ vyn;
	end

	// stage 2: coefficients
	logic signed [65:0] hsum;
	logic [63:0] csum, psum;
	logic        vld_s2;
	side_t       side_s2;

	always_comb begin
		csum = dxx_s1 + dyy_s1;
		psum = vxx_s1 + vyy_s1;
		hsum = (hxn_s1 ? -$signed({2'b00, hx_s1}) : $signed({2'b00, hx_s1}))
		     + (hyn_s1 ? -$signed({2'b00, hy_s1}) : $signed({2'b00, hy_s1}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		side_s2.c    <= csum;
		side_s2.aneg <= psum < ss_s1;
		side_s2.am   <= (psum < ss_s1) ? (ss_s1 - psum) : (psum - ss_s1);
		side_s2.hneg <= hsum < 0;
		side_s2.hm   <= (hsum < 0) ? 64'(-hsum) : 64'(hsum);
		side_s2.ok   <= 1'b0;
	end

	// stage 3: partial products of h*h and a*c
	logic        vld_s3;
	side_t       side_s3;
	logic [63:0] hh00_s3, hh01_s3, hh11_s3;
	logic [63:0] ac00_s3, ac01_s3, ac10_s3, ac11_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		side_s3 <= side_s2;
		hh00_s3 <= 64'(side_s2.hm[31:0]) * 64'(side_s2.hm[31:0]);
		hh01_s3 <= 64'(side_s2.hm[31:0]) * 64'(side_s2.hm[63:32]);
		hh11_s3 <= 64'(side_s2.hm[63:32]) * 64'(side_s2.hm[63:32]);
		ac00_s3 <= 64'(side_s2.am[31:0]) * 64'(side_s2.c[31:0]);
		ac01_s3 <= 64'(side_s2.am[31:0]) * 64'(side_s2.c[63:32]);
		ac10_s3 <= 64'(side_s2.am[63:32]) * 64'(side_s2.c[31:0]);
		ac11_s3 <= 64'(side_s2.am[63:32]) * 64'(side_s2.c[63:32]);
	end

	// stage 4: full products
	logic         vld_s4;
	side_t        side_s4;
	logic [127:0] hh_s4, ac_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		side_s4 <= side_s3;
		hh_s4   <= (128'(hh11_s3) << 64) + (128'(hh01_s3) << 33) + 128'(hh00_s3);
		ac_s4   <= (128'(ac11_s3) << 64) + (128'(ac01_s3) << 32)
		         + (128'(ac10_s3) << 32) + 128'(ac00_s3);
	end

	// stage 5: discriminant
	logic         vld_s5;
	side_t        side_s5;
	side_t        side5_d;
	logic [127:0] disc_s5;

	always_comb begin
		side5_d    = side_s4;
		side5_d.ok = side_s4.aneg || (hh_s4 >= ac_s4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		side_s5 <= side5_d;
		disc_s5 <= side_s4.aneg ? (hh_s4 + ac_s4) : (hh_s4 - ac_s4);
	end

	// square root
	logic              sq_vld;
	logic [ROOT_W-1:0] sq_root;
	side_t             sq_side;

	icpt_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s5),
		.in_rad   (disc_s5),
		.in_side  (side_s5),
		.out_vld  (sq_vld),
		.out_root (sq_root),
		.out_side (sq_side)
	);

	// stage 6: root choice and division operands
	logic signed [65:0] hs, nm, np;
	logic [64:0]        nmag;
	logic               qfound, lfound, lin;
	logic               vld_s6, found_s6;
	logic [NUM_W-1:0]   num_s6;
	logic [MAG_W-1:0]   den_s6;

	always_comb begin
		hs = sq_side.hneg ? -$signed({2'b00, sq_side.hm}) : $signed({2'b00, sq_side.hm});
		nm = -hs - $signed({2'b00, sq_root});
		np = -hs + $signed({2'b00, sq_root});
		lin    = sq_side.am == '0;
		lfound = (sq_side.hm != '0) && (sq_side.c != '0) && sq_side.hneg;
		if (sq_side.aneg) begin
			qfound = sq_side.ok && ((np < 0) || (nm < 0));
			nmag   = (np < 0) ? 65'(-np) : 65'(-nm);
		end else begin
			qfound = sq_side.ok && ((nm > 0) || (np > 0));
			nmag   = (nm > 0) ? 65'(nm) : 65'(np);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		found_s6 <= lin ? lfound : qfound;
		num_s6   <= lin ? (NUM_W'(sq_side.c) << (FRAC_BITS - 1))
		                : (NUM_W'(nmag) << FRAC_BITS);
		den_s6   <= lin ? sq_side.hm : sq_side.am;
	end

	// division
	logic             dv_vld, dv_found, dv_sat;
	logic [QUO_W-1:0] dv_quo;

	icpt_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (vld_s6),
		.in_found  (found_s6),
		.in_num    (num_s6),
		.in_den    (den_s6),
		.out_vld   (dv_vld),
		.out_found (dv_found),
		.out_sat   (dv_sat),
		.out_quo   (dv_quo)
	);

	always_comb begin
		done            = dv_vld;
		res.no_solution = !dv_found;
		res.saturated   = dv_found && dv_sat;
		if (!dv_found) begin
			res.meet_time = '0;
		end else if (dv_sat) begin
			res.meet_time = '1;
		end else begin
			res.meet_time = dv_quo;
		end
	end

	a_nosol_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.no_solution |-> res.meet_time == '0)
		else $error("no solution result with nonzero time");

	a_sat_ones: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.saturated |-> res.meet_time == '1 && !res.no_solution)
		else $error("saturated result not all ones");

	a_lin_found: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 && found_s6 |-> den_s6 != '0)
		else $error("zero divisor on a solvable request");

	a_busy_low: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 |=> !busy)
		else $error("busy raised while pipeline runs");

endmodule

// ----- tb/sv/intercept_time_checker.sv -----
// ----------------------------------------------------------------------------
// intercept_time_checker
// predicts the meeting time of every accepted request and compares each
// result with the oldest prediction, in order
// ----------------------------------------------------------------------------
module intercept_time_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           busy,
	input  icpt_pkg::in_t  req,
	input  logic           done,
	input  icpt_pkg::out_t res,
	output int             fail_count,
	output int             pending
);
	import icpt_pkg::*;

	out_t expected_q[$];

	// exact signed arithmetic on the raw values, 192 bits is ample
	function automatic logic [63:0] isqrt(logic [191:0] v);
		logic [63:0] r;
		logic [63:0] c;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if ({128'd0, c} * {128'd0, c} <= v)
				r = c;
		end
		return r;
	endfunction

	function automatic out_t predict_meet(in_t it);
		logic signed [191:0] dx, dy, vx, vy, s, c, a, h, disc, r, m, p, num, t;
		out_t o;
		logic found;
		dx = it.disp_x;
		dy = it.disp_y;
		vx = it.vel_x;
		vy = it.vel_y;
		s = {161'd0, it.pursuer_speed};
		c = dx * dx + dy * dy;
		a = vx * vx + vy * vy - s * s;
		h = dx * vx + dy * vy;
		found = 1'b0;
		num = 0;
		t = 0;
		if (a == 0) begin
			if (h != 0 && c != 0 && h < 0) begin
				t = (c <<< (FRAC_BITS - 1)) / (-h);
				found = 1'b1;
			end
		end else begin
			disc = h * h - a * c;
			if (disc >= 0) begin
				r = {128'd0, isqrt(disc)};
				m = -h - r;
				p = -h + r;
				if (a > 0) begin
					if (m > 0) begin
						num = m;
						found = 1'b1;
					end else if (p > 0) begin
						num = p;
						found = 1'b1;
					end
				end else begin
					if (p < 0) begin
						num = -p;
						found = 1'b1;
					end else if (m < 0) begin
						num = -m;
						found = 1'b1;
					end
				end
				if (found)
					t = (num <<< FRAC_BITS) / (a > 0 ? a : -a);
			end
		end
		if (!found)
			o = '{meet_time: '0, no_solution: 1'b1, saturated: 1'b0};
		else if (t > 192'hFFFFFFFF)
			o = '{meet_time: '1, no_solution: 1'b0, saturated: 1'b1};
		else
			o = '{meet_time: t[31:0], no_solution: 1'b0, saturated: 1'b0};
		return o;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		out_t e;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (start && !busy)
				expected_q.push_back(predict_meet(req));
			if (done) begin
				if (expected_q.size() == 0) begin
					$error("result with no request waiting: %h", res);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_q.pop_front();
					if (e.meet_time !== res.meet_time)
						$error("meet_time expected %h actual %h", e.meet_time, res.meet_time);
					if (e.no_solution !== res.no_solution)
						$error("no_solution expected %b actual %b", e.no_solution,
							res.no_solution);
					if (e.saturated !== res.saturated)
						$error("saturated expected %b actual %b", e.saturated, res.saturated);
					if (e !== res)
						fail_count <= fail_count + 1;
				end
			end
		end
	end

endmodule

// ----- tb/sv/intercept_time_solver_test.sv -----
// ----------------------------------------------------------------------------
// intercept_time_solver_test
// drives directed corner requests then random pursuit geometry, with random
// gaps and drain pauses; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module intercept_time_solver_test;
	import icpt_pkg::*;

	localparam int LIMIT = 400000;

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	in_t   req;
	logic  done;
	out_t  res;
	int    fail_count;
	int    pending;
	int    cycle_count;
	int    sent;

	intercept_time_solver dut (.*);

	intercept_time_checker u_checker (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic logic [31:0] rand_word(int mode);
		case (mode)
			0: return $urandom();
			1: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
			2: return $signed($urandom_range(0, 1 << 24)) - (1 << 23);
			default: return $urandom_range(0, 3) == 0 ? 32'h80000000 : 32'h7FFFFFFF;
		endcase
	endfunction

	// one request: wait out busy, hold for the accepting edge
	task automatic send_request(in_t it, logic gaps);
		while (gaps && $urandom_range(0, 99) < 21)
			@(negedge clk) start <= 1'b0;
		@(negedge clk);
		start <= 1'b1;
		req <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sent++;
	endtask

	task automatic send_random(int n, logic gaps);
		in_t it;
		int mode;
		logic [31:0] sp;
		for (int i = 0; i < n; i++) begin
			mode = $urandom_range(0, 9);
			mode = mode < 2 ? 0 : mode < 5 ? 1 : mode < 9 ? 2 : 3;
			it.disp_x = rand_word(mode);
			it.disp_y = rand_word(mode);
			it.vel_x = rand_word(mode);
			it.vel_y = rand_word(mode);
			sp = rand_word(mode);
			it.pursuer_speed = 31'(sp[31] ? -sp : sp);
			// equal speeds give the linear case
			if ($urandom_range(0, 7) == 0) begin
				it.vel_y = 0;
				it.pursuer_speed = 31'(it.vel_x[31] ? -it.vel_x : it.vel_x);
			end
			if ($urandom_range(0, 3) == 0)
				it.pursuer_speed = 31'($urandom());
			send_request(it, gaps);
		end
	endtask

	initial begin
		in_t it;
		logic [31:0] corners[6] = '{32'h0, 32'h1, 32'hFFFFFFFF, 32'h7FFFFFFF,
			32'h80000000, 32'h00010000};
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cycle_count = 0;
		sent = 0;
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		// directed: all zero, linear case with approach, recede, crossing motion,
		// negative discriminant, saturation, field extremes
		send_request('0, 1'b0);
		send_request('{32'h00100000, 0, -32'sh00010000, 0, 31'h00010000}, 1'b0);
		send_request('{32'h00100000, 0, 32'sh00010000, 0, 31'h00010000}, 1'b0);
		send_request('{32'h00100000, 0, 0, 32'sh00010000, 31'h00010000}, 1'b0);
		send_request('{32'h00100000, 0, 0, 32'sh00020000, 31'h00010000}, 1'b0);
		send_request('{32'h00100000, 0, 32'sh00020000, 0, 31'h00010000}, 1'b0);
		send_request('{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h1, 0, 31'h2}, 1'b0);
		send_request('{32'h1, 0, -32'sh1, 0, 31'h7FFFFFFF}, 1'b0);
		send_request('{32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
			31'h7FFFFFFF}, 1'b0);
		for (int i = 0; i < 14; i++) begin
			it.disp_x = corners[$urandom_range(0, 5)];
			it.disp_y = corners[$urandom_range(0, 5)];
			it.vel_x = corners[$urandom_range(0, 5)];
			it.vel_y = corners[$urandom_range(0, 5)];
			it.pursuer_speed = 31'(corners[$urandom_range(0, 5)]);
			send_request(it, 1'b0);
		end
		send_random(400, 1'b1);
		// drain pause
		@(negedge clk) start <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		send_random(250, 1'b0);
		send_random(400, 1'b1);
		@(negedge clk) start <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
		$display("%0d requests sent: corner fields, linear and quadratic cases,", sent);
		$display("no-solution and saturating times, with and without gaps");
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
